// File: sv/ple_pkg.sv
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

  // Default list capacity
  localparam int DEPTH_DEFAULT = 16;

  // Field widths
  localparam int OP_W    = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 5;
  localparam int IN_W    = 48;  // opcode, position, rank, value: 45 bits, byte padded
  localparam int OUT_W   = 40;  // status, read value, count: 39 bits, byte padded

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_ERASE     = 3'd1,
    OP_PUSH_HEAD = 3'd2,
    OP_POP_HEAD  = 3'd3,
    OP_PUSH_TAIL = 3'd4,
    OP_POP_TAIL  = 3'd5,
    OP_READ_END  = 3'd6,
    OP_CLEAR     = 3'd7
  } ple_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } ple_status_t;

  // Per-cycle shift command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a slot at the target, shift tail side toward the end
    logic del;  // close the slot at the target, shift tail side toward the head
  } cell_ctl_t;

endpackage

// File: sv/ple_cell.sv
// One list slot: holds an entry and shifts to or from its neighbors.
`timescale 1ns / 1ps

module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [IW-1:0]           pos,
  input  logic signed [VAL_W-1:0] wr_value,
  input  logic signed [VAL_W-1:0] left_in,
  input  logic signed [VAL_W-1:0] right_in,
  input  logic [IW-1:0]           rd_idx,
  output logic signed [VAL_W-1:0] data_out,
  output logic signed [VAL_W-1:0] rd_out
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic signed [VAL_W-1:0] data;

  // Shift update: insert pulls from the head side, erase from the tail side
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (MY_IDX == pos) begin
        data <= wr_value;
      end else if (MY_IDX > pos) begin
        data <= left_in;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= pos) begin
        data <= right_in;
      end
    end
  end

  assign data_out = data;

  // Read tap, zero unless selected
  assign rd_out = (MY_IDX == rd_idx) ? data : '0;

endmodule

// File: sv/positional_list_engine_core.sv
// Top level of the positional list engine: command decode, cell row, result register.
// The result is registered and appears in the cycle after the input transfer.
// Throughput: one command per cycle while results are taken; every cell shifts in
// parallel, so middle inserts and erases cost the same as pushes and pops.
// The input is stalled only while the result register is full and not taken.
// Reset clears the entry count and the result valid; entry contents are not cleared.
`timescale 1ns / 1ps

module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // opcode, position, rank_from_end, value, pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata   // status, read_value, item_count, pad
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // Input fields
  ple_op_t                 opcode;
  logic [POS_W-1:0]        position;
  logic [POS_W-1:0]        rank_from_end;
  logic signed [VAL_W-1:0] value;

  assign opcode        = ple_op_t'(s_tdata[2:0]);
  assign position      = s_tdata[7:3];
  assign rank_from_end = s_tdata[12:8];
  assign value         = s_tdata[44:13];

  // Control state
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;

  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] rank_ext;
  logic [CMPW-1:0] tail_idx;
  logic [CMPW-1:0] rd_ext;
  logic            full;
  logic            empty;

  ple_status_t     status;
  cell_ctl_t       ctl;
  cell_ctl_t       ctl_gated;
  logic [IW-1:0]   target;
  logic [IW-1:0]   rd_idx;
  logic            rd_hit;

  assign accept   = s_tvalid && s_tready;
  assign cnt_ext  = CMPW'(count);
  assign pos_ext  = CMPW'(position);
  assign rank_ext = CMPW'(rank_from_end);
  assign tail_idx = cnt_ext - CMPW'(1);
  assign rd_ext   = cnt_ext - rank_ext;
  assign full     = (cnt_ext == CMPW'(DEPTH));
  assign empty    = (count == '0);
  assign rd_idx   = rd_ext[IW-1:0];

  // Command decode
  always_comb begin
    status     = ST_OK;
    ctl        = '0;
    target     = '0;
    rd_hit     = 1'b0;
    count_next = count;
    unique case (opcode) inside
      OP_INSERT, OP_PUSH_HEAD, OP_PUSH_TAIL: begin
        if (full) begin
          status = ST_FULL;
        end else if (opcode == OP_INSERT && pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else begin
          ctl.ins    = 1'b1;
          count_next = count + CW'(1);
          if (opcode == OP_INSERT) begin
            target = pos_ext[IW-1:0];
          end else if (opcode == OP_PUSH_TAIL) begin
            target = cnt_ext[IW-1:0];
          end
        end
      end
      OP_ERASE, OP_POP_HEAD, OP_POP_TAIL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (opcode == OP_ERASE && pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          ctl.del    = 1'b1;
          count_next = count - CW'(1);
          if (opcode == OP_ERASE) begin
            target = pos_ext[IW-1:0];
          end else if (opcode == OP_POP_TAIL) begin
            target = tail_idx[IW-1:0];
          end
        end
      end
      OP_READ_END: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (rank_ext == '0 || rank_ext > cnt_ext) begin
          status = ST_RANGE;
        end else begin
          rd_hit = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign ctl_gated.ins = ctl.ins && accept;
  assign ctl_gated.del = ctl.del && accept;

  // Row of cells
  logic signed [VAL_W-1:0] cell_data [DEPTH];
  logic signed [VAL_W-1:0] cell_rd   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_in;
    logic signed [VAL_W-1:0] right_in;

    if (i == 0) begin : g_head
      assign left_in = value;
    end else begin : g_left
      assign left_in = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_in = cell_data[i];
    end else begin : g_right
      assign right_in = cell_data[i+1];
    end

    ple_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl_gated),
      .pos      (target),
      .wr_value (value),
      .left_in  (left_in),
      .right_in (right_in),
      .rd_idx   (rd_idx),
      .data_out (cell_data[i]),
      .rd_out   (cell_rd[i])
    );
  end

  // Merge read taps; only the selected cell drives nonzero
  logic signed [VAL_W-1:0] rd_merge;

  always_comb begin
    rd_merge = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_merge = rd_merge | cell_rd[i];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Result register
  logic                    out_valid;
  ple_status_t             out_status;
  logic signed [VAL_W-1:0] out_value;
  logic [CNT_W-1:0]        out_count;
  logic [CMPW-1:0]         cnt_next_ext;

  assign cnt_next_ext = CMPW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status;
      out_value  <= rd_hit ? rd_merge : '0;
      out_count  <= cnt_next_ext[CNT_W-1:0];
    end
  end

  assign s_tready = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_count, out_value, out_status};

endmodule

// File: test/tb.sv
// Testbench for the positional list engine: directed and random list commands, scoreboard check.
`timescale 1ns / 1ps

module tb;
  import ple_pkg::*;

  localparam int CAP         = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_CMDS   = 950;
  localparam int IDLE_PCT    = 21;

  // Expected response for one command
  typedef struct {
    ple_status_t status;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] item_count;
  } list_resp_t;

  // List model plus queue of responses still owed by the block
  class list_scoreboard;
    logic [VAL_W-1:0] entries[$];
    list_resp_t owed[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int size();
      return entries.size();
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function ple_status_t place(int pos, logic [VAL_W-1:0] v);
      if (entries.size() >= CAP) return ST_FULL;
      if (pos > entries.size()) return ST_RANGE;
      entries.insert(pos, v);
      return ST_OK;
    endfunction

    function ple_status_t remove(int pos);
      if (entries.size() == 0) return ST_EMPTY;
      if (pos >= entries.size()) return ST_RANGE;
      entries.delete(pos);
      return ST_OK;
    endfunction

    // Apply one accepted command to the list and queue its response
    function void note_command(logic [IN_W-1:0] word);
      ple_op_t op;
      int pos;
      int rank;
      logic [VAL_W-1:0] v;
      list_resp_t r;
      op   = ple_op_t'(word[2:0]);
      pos  = int'(word[7:3]);
      rank = int'(word[12:8]);
      v    = word[44:13];
      r.status = ST_OK;
      r.read_value = '0;
      case (op)
        OP_INSERT:    r.status = place(pos, v);
        OP_ERASE:     r.status = remove(pos);
        OP_PUSH_HEAD: r.status = place(0, v);
        OP_POP_HEAD:  r.status = remove(0);
        OP_PUSH_TAIL: r.status = place(entries.size(), v);
        OP_POP_TAIL:  r.status = remove(entries.size() - 1);
        OP_READ_END: begin
          if (entries.size() == 0) r.status = ST_EMPTY;
          else if (rank == 0 || rank > entries.size()) r.status = ST_RANGE;
          else r.read_value = entries[entries.size() - rank];
        end
        default:      entries.delete();
      endcase
      r.item_count = CNT_W'(entries.size());
      owed.push_back(r);
    endfunction

    // Compare one response transfer against the oldest owed response
    function void check_result(logic [OUT_W-1:0] data);
      list_resp_t r;
      if (owed.size() == 0) begin
        $error("response with nothing outstanding: %h", data);
        errors++;
        return;
      end
      r = owed.pop_front();
      if (data[1:0] != r.status) begin
        $error("status: expected %0d, got %0d", r.status, data[1:0]);
        errors++;
      end
      if (data[33:2] != r.read_value) begin
        $error("read_value: expected %h, got %h", r.read_value, data[33:2]);
        errors++;
      end
      if (data[38:34] != r.item_count) begin
        $error("item_count: expected %0d, got %0d", r.item_count, data[38:34]);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  list_scoreboard sb;
  logic calm = 1'b0;  // both sides run without gaps while set
  int cycles = 0;

  positional_list_engine_core #(.DEPTH(CAP)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Response side: random backpressure and checking
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] pack_cmd(ple_op_t op, logic [POS_W-1:0] pos,
                                               logic [POS_W-1:0] rank,
                                               logic [VAL_W-1:0] v);
    return {3'b000, v, rank, pos, op};
  endfunction

  // Present one command, with random gaps, and record it once taken
  task automatic send_cmd(logic [IN_W-1:0] word);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(word);
  endtask

  task automatic send(ple_op_t op, int pos, int rank, logic [VAL_W-1:0] v);
    send_cmd(pack_cmd(op, POS_W'(pos), POS_W'(rank), v));
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Random command shaped by the episode: 0 grow, 1 shrink, 2 mixed, 3 noise
  function automatic logic [IN_W-1:0] pick_cmd(int mode);
    ple_op_t op;
    int n;
    int pos;
    int rank;
    int roll;
    n = sb.size();
    roll = $urandom_range(0, 99);
    if (mode == 3) return pack_cmd(ple_op_t'($urandom_range(0, 7)),
                                   POS_W'($urandom_range(0, 31)),
                                   POS_W'($urandom_range(0, 31)), $urandom);
    case (mode)
      0: op = (roll < 30) ? OP_INSERT : (roll < 50) ? OP_PUSH_HEAD :
              (roll < 75) ? OP_PUSH_TAIL : (roll < 90) ? OP_READ_END :
              ple_op_t'($urandom_range(0, 7));
      1: op = (roll < 30) ? OP_ERASE : (roll < 50) ? OP_POP_HEAD :
              (roll < 70) ? OP_POP_TAIL : (roll < 88) ? OP_READ_END :
              ple_op_t'($urandom_range(0, 6));
      default: op = (roll < 3) ? OP_CLEAR : (roll < 30) ? OP_READ_END :
                    ple_op_t'($urandom_range(0, 5));
    endcase
    pos  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, n) : $urandom_range(0, 31);
    rank = ($urandom_range(0, 9) < 8) ? $urandom_range(0, n + 1) : $urandom_range(0, 31);
    return pack_cmd(op, POS_W'(pos), POS_W'(rank), pick_value());
  endfunction

  initial begin
    int mode;
    int left;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list errors, extremes of value, range edges, clear
    send(OP_CLEAR, 0, 0, 0);
    send(OP_POP_HEAD, 0, 0, 0);
    send(OP_POP_TAIL, 0, 0, 0);
    send(OP_ERASE, 0, 0, 0);
    send(OP_READ_END, 0, 1, 0);
    send(OP_PUSH_HEAD, 0, 0, 32'h8000_0000);
    send(OP_PUSH_TAIL, 0, 0, 32'h7fff_ffff);
    send(OP_INSERT, 1, 0, 32'h0000_0000);
    send(OP_INSERT, 31, 0, 32'h1234_5678);
    send(OP_INSERT, 4, 0, 32'h1234_5678);
    send(OP_READ_END, 0, 0, 0);
    send(OP_READ_END, 0, 31, 0);
    send(OP_READ_END, 0, 4, 0);
    send(OP_READ_END, 0, 1, 0);
    send(OP_READ_END, 0, 3, 0);
    send(OP_ERASE, 3, 0, 0);
    send(OP_ERASE, 1, 0, 0);
    send(OP_POP_HEAD, 0, 0, 0);
    send(OP_PUSH_TAIL, 0, 0, 32'hffff_ffff);
    send(OP_CLEAR, 0, 0, 0);
    send(OP_PUSH_TAIL, 0, 0, 32'hffff_ffff);
    send(OP_READ_END, 0, 1, 0);
    send(OP_POP_TAIL, 0, 0, 0);

    // Random episodes; grow runs push the list into the full case
    mode = 0;
    left = 0;
    for (int i = 0; i < RAND_CMDS; i++) begin
      if (left == 0) begin
        left = $urandom_range(10, 40);
        mode = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : 3;
      end
      left--;
      calm <= (i >= 300 && i < 500);
      send_cmd(pick_cmd(mode));
    end
    s_tvalid <= 1'b0;
    calm <= 1'b0;

    // Drain outstanding responses, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: positional_list_engine_core.f
sv/ple_pkg.sv
sv/ple_cell.sv
sv/positional_list_engine_core.sv
test/tb.sv
